/* src/tkri_pkg.sv */
// Shared types, constants and helpers for the top-K rank insertion block.
package tkri_pkg;

    localparam int LIST_DEPTH = 8;
    localparam int NUM_LISTS  = 2;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int RANK_W     = 3;
    localparam int METRIC_W   = 48;
    localparam int SHARE_W    = 15;

    localparam logic [1:0] OP_OFFER = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic LIST_CPU = 1'b0;
    localparam logic LIST_MEM = 1'b1;

    typedef struct packed {
        logic [1:0]          operation;
        logic                by_memory;
        logic [31:0]         process_id;
        logic [63:0]         create_time;
        logic [SHARE_W-1:0]  cpu_share;
        logic [METRIC_W-1:0] private_size;
    } t_in;

    typedef struct packed {
        logic                accepted;
        logic [RANK_W-1:0]   rank;
        logic                entry_valid;
        logic [31:0]         out_process_id;
        logic [63:0]         out_create_time;
        logic [SHARE_W-1:0]  out_cpu_share;
        logic [METRIC_W-1:0] out_private_size;
        logic                last;
    } t_out;

    typedef struct packed {
        logic [31:0]         process_id;
        logic [63:0]         create_time;
        logic [SHARE_W-1:0]  cpu_share;
        logic [METRIC_W-1:0] private_size;
    } t_entry;

    typedef struct packed {
        logic load_single;
        logic do_offer;
        logic do_clear;
        logic read_start;
        logic read_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_list_empty;
        logic rd_last;
    } t_dp_status;

    // Rank field wraps modulo eight when the list is deeper than eight.
    function automatic logic [RANK_W-1:0] to_rank(input logic [CNT_W-1:0] v);
        logic [CNT_W+RANK_W-1:0] w;
        w = (CNT_W + RANK_W)'(v);
        return w[RANK_W-1:0];
    endfunction

endpackage

/* src/tkri_ctrl.sv */
// Controller state machine: input and output handshakes and read sequencing.
module tkri_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  tkri_pkg::t_dp_status  i_status,
    output tkri_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_operation)
                        tkri_pkg::OP_OFFER: begin
                            o_cmd.do_offer    = 1'b1;
                            o_cmd.load_single = 1'b1;
                        end
                        tkri_pkg::OP_CLEAR: begin
                            o_cmd.do_clear    = 1'b1;
                            o_cmd.load_single = 1'b1;
                        end
                        tkri_pkg::OP_READ: begin
                            if (i_status.in_list_empty) begin
                                o_cmd.load_single = 1'b1;
                            end else begin
                                o_cmd.read_start = 1'b1;
                                n_state          = S_READ;
                            end
                        end
                        default: begin
                            o_cmd.load_single = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.read_emit = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_single || o_cmd.read_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/tkri_datapath.sv */
// Datapath: both ranked lists, slot comparators, insertion shift and result register.
module tkri_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tkri_pkg::t_in         i_in_data,
    input  tkri_pkg::t_dp_cmd     i_cmd,
    output tkri_pkg::t_dp_status  o_status,
    output tkri_pkg::t_out        o_out_data
);

    localparam int D = tkri_pkg::LIST_DEPTH;
    localparam int L = tkri_pkg::NUM_LISTS;

    tkri_pkg::t_entry              r_list [0:L-1][0:D-1];
    logic [tkri_pkg::CNT_W-1:0]    r_count [0:L-1];
    logic                          r_rd_sel;
    logic [tkri_pkg::IDX_W-1:0]    r_rd_idx;
    tkri_pkg::t_out                r_out_data, n_out_data;

    logic                          sel;
    logic [tkri_pkg::METRIC_W-1:0] key [0:L-1];
    logic [D-1:0]                  gt [0:L-1];
    logic [tkri_pkg::CNT_W-1:0]    n_cur;
    logic [tkri_pkg::CNT_W-1:0]    at;
    logic                          offer_ok;
    tkri_pkg::t_entry              new_entry;
    tkri_pkg::t_entry              rd_entry;

    assign sel = i_in_data.by_memory;

    assign new_entry.process_id   = i_in_data.process_id;
    assign new_entry.create_time  = i_in_data.create_time;
    assign new_entry.cpu_share    = i_in_data.cpu_share;
    assign new_entry.private_size = i_in_data.private_size;

    assign key[tkri_pkg::LIST_CPU] = tkri_pkg::METRIC_W'(i_in_data.cpu_share);
    assign key[tkri_pkg::LIST_MEM] = i_in_data.private_size;

    // Each list compares the offered key against every occupied slot at once.
    always_comb begin
        for (int j = 0; j < D; j++) begin
            gt[tkri_pkg::LIST_CPU][j] =
                (tkri_pkg::CNT_W'(j) < r_count[tkri_pkg::LIST_CPU]) &&
                (key[tkri_pkg::LIST_CPU] >
                 tkri_pkg::METRIC_W'(r_list[tkri_pkg::LIST_CPU][j].cpu_share));
            gt[tkri_pkg::LIST_MEM][j] =
                (tkri_pkg::CNT_W'(j) < r_count[tkri_pkg::LIST_MEM]) &&
                (key[tkri_pkg::LIST_MEM] > r_list[tkri_pkg::LIST_MEM][j].private_size);
        end
    end

    // The insertion point is the first slot the key strictly exceeds, else the end.
    always_comb begin
        n_cur = r_count[sel];
        at    = n_cur;
        for (int j = D - 1; j >= 0; j--) begin
            if (gt[sel][j]) begin
                at = tkri_pkg::CNT_W'(j);
            end
        end
        offer_ok = (key[sel] != '0) && (at < tkri_pkg::CNT_W'(D));
    end

    assign rd_entry = r_list[r_rd_sel][r_rd_idx];

    assign o_status.in_list_empty = (r_count[sel] == '0);
    assign o_status.rd_last =
        ((tkri_pkg::CNT_W'(r_rd_idx) + tkri_pkg::CNT_W'(1)) == r_count[r_rd_sel]);

    always_comb begin
        n_out_data = '0;
        if (i_cmd.read_emit) begin
            n_out_data.rank             = tkri_pkg::to_rank(tkri_pkg::CNT_W'(r_rd_idx));
            n_out_data.entry_valid      = 1'b1;
            n_out_data.out_process_id   = rd_entry.process_id;
            n_out_data.out_create_time  = rd_entry.create_time;
            n_out_data.out_cpu_share    = rd_entry.cpu_share;
            n_out_data.out_private_size = rd_entry.private_size;
            n_out_data.last             = o_status.rd_last;
        end else begin
            n_out_data.accepted = i_cmd.do_offer && offer_ok;
            n_out_data.rank     = (i_cmd.do_offer && offer_ok) ?
                                  tkri_pkg::to_rank(at) : '0;
            n_out_data.last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single || i_cmd.read_emit) begin
            r_out_data <= n_out_data;
        end
        if (i_cmd.read_start) begin
            r_rd_sel <= sel;
            r_rd_idx <= '0;
        end else if (i_cmd.read_emit) begin
            r_rd_idx <= r_rd_idx + tkri_pkg::IDX_W'(1);
        end
        if (i_cmd.do_offer && offer_ok) begin
            for (int j = 0; j < D; j++) begin
                if (tkri_pkg::CNT_W'(j) == at) begin
                    r_list[sel][j] <= new_entry;
                end
            end
            // Entries below the insertion point move down one slot.
            for (int j = 1; j < D; j++) begin
                if (tkri_pkg::CNT_W'(j) > at) begin
                    r_list[sel][j] <= r_list[sel][j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count[tkri_pkg::LIST_CPU] <= '0;
            r_count[tkri_pkg::LIST_MEM] <= '0;
        end else if (i_cmd.do_clear) begin
            r_count[tkri_pkg::LIST_CPU] <= '0;
            r_count[tkri_pkg::LIST_MEM] <= '0;
        end else if (i_cmd.do_offer && offer_ok && (n_cur < tkri_pkg::CNT_W'(D))) begin
            r_count[sel] <= n_cur + tkri_pkg::CNT_W'(1);
        end
    end

    assign o_out_data = r_out_data;

endmodule

/* src/top_k_rank_insertion.sv */
// Offer, clear, empty-list read, other code: result in the cycle after the input transfer.
// Offers and clears sustain one transfer per cycle while results are taken each cycle.
// A read of n stored entries yields n results via the read state and the result register,
// one per cycle while results are taken; the next input is taken as the last one leaves.
// Reset (synchronous, active low) empties both lists and drops any pending result;
// stored entries are not cleared and are never read until written again.
module top_k_rank_insertion (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tkri_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tkri_pkg::t_out  o_out_data
);

    tkri_pkg::t_dp_cmd    cmd;
    tkri_pkg::t_dp_status status;

    tkri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_in_data.operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tkri_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

/* src/tkri_checker.sv */
// Port-level checker for the top-K rank insertion block, bound to the top level.
module tkri_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  tkri_pkg::t_in   i_in_data,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  tkri_pkg::t_out  o_out_data
);

    // A pending result stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed or dropped before transfer");

    // Anything but a read produces its single result on the next cycle.
    a_single_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.operation != tkri_pkg::OP_READ))
        |=> (o_out_valid && o_out_data.last))
        else $error("single result missing after input transfer");

    // An accepted offer result never carries an entry and is marked last.
    a_offer_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted) |-> (!o_out_data.entry_valid && o_out_data.last))
        else $error("offer result carries entry data");

    // No new input is taken in the middle of a read burst.
    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready)
        else $error("input taken during a read burst");

endmodule

bind top_k_rank_insertion tkri_checker u_tkri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
